FILE: rtl/hsw_pkg.sv
// shared types and constants for the heap sort block
`timescale 1ns / 1ps
`default_nettype none
package hsw_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  // one stored item, weight above value
  typedef struct packed {
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] value;
  } hsw_entry_t;

  localparam int ENTRY_W = $bits(hsw_entry_t);

endpackage
`default_nettype wire

FILE: rtl/hsw_mem.sv
// item store: one write port, two read ports with registered read data
`timescale 1ns / 1ps
`default_nettype none
module hsw_mem
  import hsw_pkg::*;
#(
  parameter int DEPTH = MAX_ITEMS_DEF,
  parameter int AW    = 6
) (
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire hsw_entry_t wr_data,
  input  wire logic [AW-1:0] rd_addr_a,
  input  wire logic [AW-1:0] rd_addr_b,
  output hsw_entry_t      rd_data_a,
  output hsw_entry_t      rd_data_b
);

  hsw_entry_t mem_r [DEPTH];
  hsw_entry_t rd_a_r;
  hsw_entry_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_r[rd_addr_a];
    rd_b_r <= mem_r[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule
`default_nettype wire

FILE: rtl/hsw_ctrl.sv
// sequencer: collects items, heapsorts them in the store, emits the sorted run
`timescale 1ns / 1ps
`default_nettype none
module hsw_ctrl
  import hsw_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF,
  parameter int AW        = 6,
  parameter int CW        = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hsw_entry_t    in_entry,
  input  wire logic          in_last,
  output logic               out_valid,
  input  wire logic          out_ready,
  output hsw_entry_t         out_entry,
  output logic               out_last,
  output logic               out_dropped,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output hsw_entry_t         mem_wdata,
  output logic [AW-1:0]      mem_raddr_a,
  output logic [AW-1:0]      mem_raddr_b,
  input  wire hsw_entry_t    mem_rdata_a,
  input  wire hsw_entry_t    mem_rdata_b
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLD_RD,
    S_BLD_LD,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_EXT_RD,
    S_EXT_WR,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t     state_r,    state_nxt;
  logic [CW-1:0] cnt_r,   cnt_nxt;
  logic          ovf_r,   ovf_nxt;
  logic [CW-1:0] n_r,     n_nxt;
  logic [CW-1:0] k_r,     k_nxt;
  logic [CW-1:0] p_r,     p_nxt;
  logic [CW-1:0] live_r,  live_nxt;
  logic          extr_r,  extr_nxt;
  logic          rok_r,   rok_nxt;
  hsw_entry_t    cur_r,   cur_nxt;
  logic          ovalid_r, ovalid_nxt;
  hsw_entry_t    oentry_r, oentry_nxt;
  logic          olast_r,  olast_nxt;
  logic          odrop_r,  odrop_nxt;

  logic [CW:0]   l_idx;
  logic [CW:0]   r_idx;
  logic          l_ok;
  logic          r_ok;
  logic          sift_done;
  logic          room;
  logic [CW-1:0] n_set;
  logic          take_l;
  logic          take_r;

  // children of the current node, heap numbering from 1
  assign l_idx = {p_r, 1'b0};
  assign r_idx = l_idx + 1'b1;
  assign l_ok  = l_idx <= {1'b0, live_r};
  assign r_ok  = r_idx <= {1'b0, live_r};
  assign room  = cnt_r < CW'(MAX_ITEMS);
  assign n_set = room ? cnt_r + 1'b1 : cnt_r;

  // left wins on strictly greater than the sifted item, right on greater than the winner
  always_comb begin
    take_l = $signed(mem_rdata_a.weight) > $signed(cur_r.weight);
    take_r = 1'b0;
    if (rok_r) begin
      if (take_l) begin
        take_r = $signed(mem_rdata_b.weight) > $signed(mem_rdata_a.weight);
      end else begin
        take_r = $signed(mem_rdata_b.weight) > $signed(cur_r.weight);
      end
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    p_nxt       = p_r;
    live_nxt    = live_r;
    extr_nxt    = extr_r;
    rok_nxt     = rok_r;
    cur_nxt     = cur_r;
    ovalid_nxt  = ovalid_r && !out_ready;
    oentry_nxt  = oentry_r;
    olast_nxt   = olast_r;
    odrop_nxt   = odrop_r;
    mem_we      = 1'b0;
    mem_waddr   = AW'(p_r - 1'b1);
    mem_wdata   = cur_r;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    sift_done   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (room) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cnt_r);
            mem_wdata = in_entry;
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            n_nxt = n_set;
            if (n_set > CW'(1)) begin
              k_nxt     = n_set >> 1;
              extr_nxt  = 1'b0;
              state_nxt = S_BLD_RD;
            end else begin
              k_nxt     = '0;
              state_nxt = S_EMIT_RD;
            end
          end
        end
      end
      S_BLD_RD: begin
        mem_raddr_a = AW'(k_r - 1'b1);
        live_nxt    = n_r;
        p_nxt       = k_r;
        state_nxt   = S_BLD_LD;
      end
      S_BLD_LD: begin
        cur_nxt   = mem_rdata_a;
        state_nxt = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        mem_raddr_a = AW'(l_idx - 1'b1);
        mem_raddr_b = AW'(l_idx);
        rok_nxt     = r_ok;
        if (l_ok) begin
          state_nxt = S_SIFT_CMP;
        end else begin
          mem_we    = 1'b1;
          sift_done = 1'b1;
        end
      end
      S_SIFT_CMP: begin
        mem_we = 1'b1;
        priority if (take_r) begin
          mem_wdata = mem_rdata_b;
          p_nxt     = r_idx[CW-1:0];
          state_nxt = S_SIFT_RD;
        end else if (take_l) begin
          mem_wdata = mem_rdata_a;
          p_nxt     = l_idx[CW-1:0];
          state_nxt = S_SIFT_RD;
        end else begin
          sift_done = 1'b1;
        end
      end
      S_EXT_RD: begin
        mem_raddr_a = '0;
        mem_raddr_b = AW'(k_r - 1'b1);
        state_nxt   = S_EXT_WR;
      end
      S_EXT_WR: begin
        // root goes to the last live slot, that slot's item sifts from the root
        mem_we    = 1'b1;
        mem_waddr = AW'(k_r - 1'b1);
        mem_wdata = mem_rdata_a;
        cur_nxt   = mem_rdata_b;
        p_nxt     = CW'(1);
        live_nxt  = k_r - 1'b1;
        state_nxt = S_SIFT_RD;
      end
      S_EMIT_RD: begin
        mem_raddr_a = AW'(k_r);
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        mem_raddr_a = AW'(k_r);
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          oentry_nxt = mem_rdata_a;
          olast_nxt  = (k_r == n_r - 1'b1);
          odrop_nxt  = ovf_r;
          if (k_r == n_r - 1'b1) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (sift_done) begin
      if (!extr_r) begin
        if (k_r == CW'(1)) begin
          extr_nxt  = 1'b1;
          k_nxt     = n_r;
          state_nxt = S_EXT_RD;
        end else begin
          k_nxt     = k_r - 1'b1;
          state_nxt = S_BLD_RD;
        end
      end else if (k_r > CW'(2)) begin
        k_nxt     = k_r - 1'b1;
        state_nxt = S_EXT_RD;
      end else begin
        k_nxt     = '0;
        state_nxt = S_EMIT_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
    end
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    p_r      <= p_nxt;
    live_r   <= live_nxt;
    extr_r   <= extr_nxt;
    rok_r    <= rok_nxt;
    cur_r    <= cur_nxt;
    oentry_r <= oentry_nxt;
    olast_r  <= olast_nxt;
    odrop_r  <= odrop_nxt;
  end

  assign out_valid   = ovalid_r;
  assign out_entry   = oentry_r;
  assign out_last    = olast_r;
  assign out_dropped = odrop_r;

endmodule
`default_nettype wire

FILE: rtl/heap_sort_by_weight.sv
// top level: item store and heapsort sequencer behind stream ports
`timescale 1ns / 1ps
`default_nettype none
// Collects (value, weight) beats until one with tlast, then sorts the set by
// signed weight with an in-place max-heap heapsort and sends it out in
// ascending weight, tlast on the final beat and tuser set on every beat of a
// set from which beats beyond MAX_ITEMS were dropped. Every sift-down step is
// a two-port read of both children from the item store, then a compare and
// write-back; each output beat is a read of the store, then a load into the
// output register, which waits while that register is full and not taken.
// The registered read of the store paces the sort. No input beat is taken
// between the final input beat and the hand-over of the last sorted beat to
// the output register.
module heap_sort_by_weight
  import hsw_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [ENTRY_W-1:0]   in_tdata,   // item_value, item_weight
  input  wire logic                 in_tlast,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [ENTRY_W-1:0]        out_tdata,  // out_value, out_weight
  output logic                      out_tlast,
  output logic [0:0]                out_tuser   // dropped
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  hsw_entry_t      in_entry;
  hsw_entry_t      out_entry;
  logic            out_dropped;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  hsw_entry_t      mem_wdata;
  logic [AW-1:0]   mem_raddr_a;
  logic [AW-1:0]   mem_raddr_b;
  hsw_entry_t      mem_rdata_a;
  hsw_entry_t      mem_rdata_b;

  assign in_entry     = hsw_entry_t'(in_tdata);
  assign out_tdata    = ENTRY_W'(out_entry);
  assign out_tuser[0] = out_dropped;

  hsw_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_entry    (in_entry),
    .in_last     (in_tlast),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_entry   (out_entry),
    .out_last    (out_tlast),
    .out_dropped (out_dropped),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

  hsw_mem #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_addr_a (mem_raddr_a),
    .rd_addr_b (mem_raddr_b),
    .rd_data_a (mem_rdata_a),
    .rd_data_b (mem_rdata_b)
  );

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// self-checking bench for heap_sort_by_weight: directed table, one over-capacity set, random sets
`timescale 1ns / 1ps
module testbench;
  import hsw_pkg::*;

  localparam int CAPACITY      = MAX_ITEMS_DEF;
  localparam int DIR_ROWS      = 24;
  localparam int RAND_ITEMS    = 42;
  localparam int CALM_FROM     = 20;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 40;

  localparam logic signed [DATA_W-1:0] W_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] W_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] weight;
    logic                     last;
    logic                     dropped;
  } sorted_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] weight;
    logic                     last;
    logic                     typed;
    sorted_beat_t             want;
  } stim_row_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [ENTRY_W-1:0] in_tdata   = '0;   // item_value, item_weight
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [ENTRY_W-1:0] out_tdata;         // out_value, out_weight
  logic               out_tlast;
  logic [0:0]         out_tuser;         // dropped

  heap_sort_by_weight #(.MAX_ITEMS(CAPACITY)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: the set being collected and the heap used to sort it
  hsw_entry_t   held_items [CAPACITY];
  int           held_count    = 0;
  bit           held_overflow = 1'b0;
  hsw_entry_t   heap_work [1:CAPACITY];
  sorted_beat_t sorted_run_q [$];

  int mismatches  = 0;
  bit calm        = 1'b0;
  int hold_cnt    = 0;
  int idle_cycles = 0;

  function automatic bit weight_above(int a, int b);
    return $signed(heap_work[a].weight) > $signed(heap_work[b].weight);
  endfunction

  function automatic void swap_slots(int a, int b);
    hsw_entry_t t;
    t            = heap_work[a];
    heap_work[a] = heap_work[b];
    heap_work[b] = t;
  endfunction

  function automatic void sift_down(int start, int live);
    int p, l, r, top;
    bit settled;
    p       = start;
    settled = 1'b0;
    while (!settled) begin
      l   = 2 * p;
      r   = l + 1;
      top = p;
      if (l <= live && weight_above(l, top)) top = l;
      if (r <= live && weight_above(r, top)) top = r;
      if (top == p) begin
        settled = 1'b1;
      end else begin
        swap_slots(p, top);
        p = top;
      end
    end
  endfunction

  // store or drop one item; on the last one sort the set and queue its beats
  function automatic void take_item(logic signed [DATA_W-1:0] v,
                                    logic signed [DATA_W-1:0] w, logic last);
    int k, n;
    if (held_count < CAPACITY) begin
      held_items[held_count] = '{weight: w, value: v};
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (last) begin
      n = held_count;
      for (k = 1; k <= n; k++) heap_work[k] = held_items[k-1];
      for (k = n / 2; k >= 1; k--) sift_down(k, n);
      for (k = n; k > 1; k--) begin
        swap_slots(k, 1);
        sift_down(1, k - 1);
      end
      for (k = 1; k <= n; k++)
        sorted_run_q.push_back('{value: heap_work[k].value, weight: heap_work[k].weight,
                                 last: (k == n), dropped: held_overflow});
      held_count    = 0;
      held_overflow = 1'b0;
    end
  endfunction

  function automatic stim_row_t plain(logic signed [DATA_W-1:0] v,
                                      logic signed [DATA_W-1:0] w, logic last);
    return '{value: v, weight: w, last: last, typed: 1'b0, want: '0};
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_weight();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return $signed($urandom_range(0, 6)) - 3;  // ties likely
    if (pick == 1) return $urandom_range(0, 1) ? W_MAX : W_MIN;
    return $urandom;
  endfunction

  task automatic send_item(logic signed [DATA_W-1:0] v, logic signed [DATA_W-1:0] w,
                           logic last, bit typed, sorted_beat_t want);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w, v};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    take_item(v, w, last);
    // a lone item comes straight back, so its beat is typed in the table
    if (typed) begin
      void'(sorted_run_q.pop_back());
      sorted_run_q.push_back(want);
    end
  endtask

  task automatic send_set(int size);
    sorted_beat_t none;
    none = '0;
    for (int i = 0; i < size; i++)
      send_item($urandom, pick_weight(), i == size - 1, 1'b0, none);
  endtask

  function automatic void check_field(string field, logic signed [DATA_W-1:0] want,
                                      logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // output stalls in random bursts, with none started once calm is set
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_cnt   <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sorted_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_run_q.size() == 0) begin
        $error("beat with nothing expected: value %0d weight %0d",
               $signed(out_tdata[DATA_W-1:0]), $signed(out_tdata[ENTRY_W-1:DATA_W]));
        mismatches++;
      end else begin
        want = sorted_run_q.pop_front();
        check_field("out_value", want.value, out_tdata[DATA_W-1:0]);
        check_field("out_weight", want.weight, out_tdata[ENTRY_W-1:DATA_W]);
        check_field("last_out", DATA_W'(want.last), DATA_W'(out_tlast));
        check_field("dropped", DATA_W'(want.dropped), DATA_W'(out_tuser[0]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t dir_table [DIR_ROWS];
    int sent;
    int size;
    dir_table = '{
      // lone items: zero, minus one and the extremes
      '{0, 0, 1'b1, 1'b1, '{0, 0, 1'b1, 1'b0}},
      '{W_MIN, W_MAX, 1'b1, 1'b1, '{W_MIN, W_MAX, 1'b1, 1'b0}},
      '{W_MAX, W_MIN, 1'b1, 1'b1, '{W_MAX, W_MIN, 1'b1, 1'b0}},
      '{-1, -1, 1'b1, 1'b1, '{-1, -1, 1'b1, 1'b0}},
      // signed order across the whole key range
      plain(1, W_MAX, 1'b0), plain(2, W_MIN, 1'b0), plain(3, 0, 1'b0), plain(4, -1, 1'b1),
      // ties
      plain(10, 5, 1'b0), plain(11, 5, 1'b0), plain(12, -3, 1'b0),
      plain(13, 5, 1'b0), plain(14, -3, 1'b0), plain(15, 5, 1'b1),
      plain(20, 7, 1'b0), plain(21, 7, 1'b1),
      // already descending, then ascending
      plain(30, 4, 1'b0), plain(31, 3, 1'b0), plain(32, 2, 1'b0),
      plain(33, 1, 1'b0), plain(34, 0, 1'b1),
      plain(40, -2, 1'b0), plain(41, -1, 1'b0), plain(42, W_MAX, 1'b1)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i])
      send_item(dir_table[i].value, dir_table[i].weight, dir_table[i].last,
                dir_table[i].typed, dir_table[i].want);

    // hold off until every directed beat is back
    in_tvalid <= 1'b0;
    while (sorted_run_q.size() != 0) @(posedge clk);

    // full store, with the dropped tail beat carrying the last flag
    send_set(CAPACITY + 1);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent >= CALM_FROM) calm = 1'b1;
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      send_set(size);
      sent += size;
    end

    in_tvalid <= 1'b0;
    while (sorted_run_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && sorted_run_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: heap_sort_by_weight.f
rtl/hsw_pkg.sv
rtl/hsw_mem.sv
rtl/hsw_ctrl.sv
rtl/heap_sort_by_weight.sv
dv/testbench.sv
